>>> rtl/core/rles_pkg.sv
// shared types and constants for the rgb led effect sequencer
// no dependencies
`timescale 1ns / 1ps

package rles_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int LEN_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_POWER_ON     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANIMATED     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STATIC_RED   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STATIC_GREEN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STATIC_BLUE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_DELAY   = 3'd6;

    localparam logic [2:0] PROF_WAVE  = 3'd1;
    localparam logic [2:0] PROF_HEART = 3'd2;
    localparam logic [2:0] PROF_FLASH = 3'd3;
    localparam logic [2:0] PROF_BLINK = 3'd4;

    localparam logic [7:0] LEVEL_FULL  = 8'd255;
    localparam logic [7:0] LEVEL_TOP   = 8'd254;
    localparam logic [7:0] HEART_LOW   = 8'd25;
    localparam logic [7:0] HEART_FALL  = 8'd26;

    localparam logic [LEN_W-1:0] HEART_STEP_MS = 16'd2;
    localparam logic [LEN_W-1:0] PAUSE_MS      = 16'd500;
    localparam logic [LEN_W-1:0] FLASH_MUL     = 16'd10;
    localparam logic [LEN_W-1:0] BLINK_MUL     = 16'd50;
    localparam logic [9:0]       FLASH_MIN_MS  = 10'd4;

    typedef struct packed {
        logic       power_on;
        logic       animated_mode;
        logic [2:0] effect_profile;
        logic [7:0] static_red;
        logic [7:0] static_green;
        logic [7:0] static_blue;
        logic [9:0] step_delay_ms;
    } rles_cfg_t;

    // red in the lowest bits
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rles_rgb_t;

endpackage

>>> rtl/core/rgb_led_effect_sequencer.sv
// top level of the rgb led effect sequencer: stream ports and output valid
// depends on rles_pkg, rles_cfg and rles_fx
`timescale 1ns / 1ps

// One input word is one millisecond tick and gives one output word with the
// red, green and blue duty levels. A word is taken every cycle unless the output
// is stalled: the effect state and the colour register update from the tick as
// it is taken, and the colour register is the output data, so a word is
// accepted whenever the output is empty or being taken in the same cycle.
// Configuration writes are taken at any time with no wait and should be made
// only while no word is in flight; a write to the profile register restarts
// the effect.

module rgb_led_effect_sequencer
#(
    parameter int DWELL_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // tick, zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // blue_level, green_level, red_level
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rles_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rles_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rles_pkg::*;

    rles_cfg_t cfg;
    rles_rgb_t colour;
    logic      restart;
    logic      step;
    logic      m_valid_reg, m_valid_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = colour;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (step)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    rles_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .restart   (restart)
    );

    rles_fx #(.DWELL_BITS(DWELL_BITS)) u_fx
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .step    (step),
        .tick    (s_tdata[0]),
        .colour  (colour)
    );

endmodule

>>> rtl/core/rles_cfg.sv
// configuration register file for the rgb led effect sequencer
// depends on rles_pkg
`timescale 1ns / 1ps

module rles_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rles_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rles_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rles_pkg::rles_cfg_t            cfg,
    output logic                           restart
);
    import rles_pkg::*;

    rles_cfg_t cfg_reg;
    logic      wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;
    assign cfg       = cfg_reg;
    assign restart   = wr && (cfg_index == REG_PROFILE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{step_delay_ms: 10'd1, default: '0};
        end
        else if (wr)
        begin
            unique case (cfg_index)
                REG_POWER_ON:     cfg_reg.power_on       <= cfg_data[0];
                REG_ANIMATED:     cfg_reg.animated_mode  <= cfg_data[0];
                REG_PROFILE:      cfg_reg.effect_profile <= cfg_data[2:0];
                REG_STATIC_RED:   cfg_reg.static_red     <= cfg_data[7:0];
                REG_STATIC_GREEN: cfg_reg.static_green   <= cfg_data[7:0];
                REG_STATIC_BLUE:  cfg_reg.static_blue    <= cfg_data[7:0];
                REG_STEP_DELAY:   cfg_reg.step_delay_ms  <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule

>>> rtl/core/rles_fx.sv
// effect state and colour update, one word per cycle while step is high and restart is low
// depends on rles_pkg
`timescale 1ns / 1ps

module rles_fx
#(
    parameter int DWELL_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rles_pkg::rles_cfg_t cfg,
    input  logic                restart,
    input  logic                step,
    input  logic                tick,
    output rles_pkg::rles_rgb_t colour
);
    import rles_pkg::*;

    rles_rgb_t             colour_reg, colour_next;
    logic [3:0]            phase_reg, phase_next;
    logic [7:0]            ramp_reg, ramp_next;
    logic [DWELL_BITS-1:0] dwell_reg, dwell_next;
    logic [1:0]            pulse_reg, pulse_next;

    logic                  out_of_range;
    logic [3:0]            ph;
    logic [7:0]            rv;
    logic [7:0]            hv;
    logic [DWELL_BITS-1:0] dw;
    logic [1:0]            pc;
    logic [1:0]            pc_inc;
    logic [9:0]            dly;
    logic [9:0]            flash_d;
    logic [LEN_W-1:0]      len;
    logic [DWELL_BITS-1:0] dw_inc;
    logic                  done;

    assign colour  = colour_reg;
    assign dly     = (cfg.step_delay_ms == 10'd0) ? 10'd1 : cfg.step_delay_ms;
    assign flash_d = (cfg.step_delay_ms < FLASH_MIN_MS) ? FLASH_MIN_MS : cfg.step_delay_ms;

    always_comb
    begin
        case (cfg.effect_profile)
            PROF_WAVE:  out_of_range = phase_reg > 4'd5;
            PROF_HEART: out_of_range = phase_reg > 4'd2;
            PROF_FLASH: out_of_range = phase_reg > 4'd5;
            default:    out_of_range = phase_reg > 4'd1;
        endcase
        ph = out_of_range ? 4'd0 : phase_reg;
        rv = out_of_range ? 8'd0 : ramp_reg;
        dw = out_of_range ? '0 : dwell_reg;
        pc = out_of_range ? 2'd0 : pulse_reg;

        case (cfg.effect_profile)
            PROF_WAVE:  len = LEN_W'(dly);
            PROF_HEART: len = (ph == 4'd2) ? PAUSE_MS : HEART_STEP_MS;
            PROF_FLASH: len = LEN_W'(flash_d) * FLASH_MUL;
            default:    len = LEN_W'(dly) * BLINK_MUL;
        endcase

        dw_inc = dw + DWELL_BITS'(1);
        done   = dw_inc >= DWELL_BITS'(len);
        pc_inc = pc + 2'd1;
        if (ph == 4'd0)
            hv = (rv < HEART_LOW) ? HEART_LOW : rv;
        else
            hv = (rv < HEART_FALL) ? HEART_FALL : rv;

        colour_next = colour_reg;
        phase_next  = phase_reg;
        ramp_next   = ramp_reg;
        dwell_next  = dwell_reg;
        pulse_next  = pulse_reg;

        if (!cfg.power_on || !cfg.animated_mode)
        begin
            colour_next = cfg.power_on ?
                          rles_rgb_t'{blue: cfg.static_blue, green: cfg.static_green,
                                      red: cfg.static_red} : rles_rgb_t'('0);
            phase_next  = 4'd0;
            ramp_next   = 8'd0;
            dwell_next  = '0;
            pulse_next  = 2'd0;
        end
        else if (tick && cfg.effect_profile >= PROF_WAVE && cfg.effect_profile <= PROF_BLINK)
        begin
            phase_next = ph;
            ramp_next  = rv;
            pulse_next = pc;
            dwell_next = done ? '0 : dw_inc;
            case (cfg.effect_profile)
                PROF_WAVE:
                begin
                    case (ph)
                        4'd0:    colour_next = '{blue: rv, green: 8'd0, red: LEVEL_FULL};
                        4'd1:    colour_next = '{blue: LEVEL_TOP, green: 8'd0, red: rv};
                        4'd2:    colour_next = '{blue: LEVEL_FULL, green: rv, red: 8'd0};
                        4'd3:    colour_next = '{blue: rv, green: LEVEL_TOP, red: 8'd0};
                        4'd4:    colour_next = '{blue: 8'd0, green: LEVEL_FULL, red: rv};
                        default: colour_next = '{blue: 8'd0, green: rv, red: LEVEL_TOP};
                    endcase
                    if (done)
                    begin
                        if (!ph[0])
                        begin
                            if (rv >= LEVEL_TOP)
                            begin
                                phase_next = ph + 4'd1;
                                ramp_next  = LEVEL_FULL;
                            end
                            else
                                ramp_next = rv + 8'd1;
                        end
                        else
                        begin
                            if (rv <= 8'd1)
                            begin
                                phase_next = (ph == 4'd5) ? 4'd0 : ph + 4'd1;
                                ramp_next  = 8'd0;
                            end
                            else
                                ramp_next = rv - 8'd1;
                        end
                    end
                end
                PROF_HEART:
                begin
                    if (ph == 4'd2)
                    begin
                        colour_next = '{blue: 8'd0, green: 8'd0, red: colour_reg.red};
                        if (done)
                        begin
                            phase_next = 4'd0;
                            ramp_next  = HEART_LOW;
                        end
                    end
                    else
                    begin
                        colour_next = '{blue: 8'd0, green: 8'd0, red: hv};
                        ramp_next   = hv;
                        if (done)
                        begin
                            if (ph == 4'd0)
                            begin
                                if (hv >= LEVEL_TOP)
                                begin
                                    phase_next = 4'd1;
                                    ramp_next  = LEVEL_FULL;
                                end
                                else
                                    ramp_next = hv + 8'd1;
                            end
                            else if (hv <= HEART_FALL)
                            begin
                                ramp_next = HEART_LOW;
                                if (pc_inc >= 2'd2)
                                begin
                                    pulse_next = 2'd0;
                                    phase_next = 4'd2;
                                end
                                else
                                begin
                                    pulse_next = pc_inc;
                                    phase_next = 4'd0;
                                end
                            end
                            else
                                ramp_next = hv - 8'd1;
                        end
                    end
                end
                PROF_FLASH:
                begin
                    case (ph)
                        4'd0:    colour_next = '{blue: 8'd0, green: 8'd0, red: LEVEL_FULL};
                        4'd2:    colour_next = '{blue: 8'd0, green: LEVEL_FULL, red: 8'd0};
                        4'd4:    colour_next = '{blue: LEVEL_FULL, green: 8'd0, red: 8'd0};
                        default: colour_next = '0;
                    endcase
                    if (done)
                        phase_next = (ph == 4'd5) ? 4'd0 : ph + 4'd1;
                end
                default:
                begin
                    colour_next = (ph == 4'd0) ?
                                  rles_rgb_t'{blue: cfg.static_blue, green: cfg.static_green,
                                              red: cfg.static_red} : rles_rgb_t'('0);
                    if (done)
                        phase_next = {ph[3:1], ~ph[0]};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= '0;
            phase_reg  <= 4'd0;
            ramp_reg   <= 8'd0;
            dwell_reg  <= '0;
            pulse_reg  <= 2'd0;
        end
        else if (restart)
        begin
            phase_reg <= 4'd0;
            ramp_reg  <= 8'd0;
            dwell_reg <= '0;
            pulse_reg <= 2'd0;
        end
        else if (step)
        begin
            colour_reg <= colour_next;
            phase_reg  <= phase_next;
            ramp_reg   <= ramp_next;
            dwell_reg  <= dwell_next;
            pulse_reg  <= pulse_next;
        end
    end

endmodule

>>> tb/tb_rgb_led_effect_sequencer.sv
// self-checking testbench for rgb_led_effect_sequencer: tick words in, colour words out
// a scoreboard class predicts every colour word, plain tasks drive the streams
// depends on rles_pkg and the rgb_led_effect_sequencer rtl
`timescale 1ns / 1ps

module tb_rgb_led_effect_sequencer;

    import rles_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int TICK_TARGET = 1150;

    class led_scoreboard;
        rles_cfg_t   regs;
        rles_rgb_t   lit;
        logic [3:0]  phase;
        logic [7:0]  ramp;
        logic [15:0] dwell;
        logic [1:0]  beats;
        rles_rgb_t   colour_queue[$];
        int          errors;

        function new();
            regs = '0;
            regs.step_delay_ms = 10'd1;
            lit = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase = '0;
            ramp = '0;
            dwell = '0;
            beats = '0;
        endfunction

        function void paint(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            lit.red = r;
            lit.green = g;
            lit.blue = b;
        endfunction

        function bit dwell_done(int unsigned len);
            dwell = dwell + 16'd1;
            if (dwell >= len)
            begin
                dwell = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function int unsigned delay_ms();
            return (regs.step_delay_ms == 10'd0) ? 1 : 32'(regs.step_delay_ms);
        endfunction

        function void wave_step();
            if (phase > 5) restart();
            case (phase)
                0:       paint(LEVEL_FULL, 8'd0, ramp);
                1:       paint(ramp, 8'd0, LEVEL_TOP);
                2:       paint(8'd0, ramp, LEVEL_FULL);
                3:       paint(8'd0, LEVEL_TOP, ramp);
                4:       paint(ramp, LEVEL_FULL, 8'd0);
                default: paint(LEVEL_TOP, ramp, 8'd0);
            endcase
            if (!dwell_done(delay_ms())) return;
            if (!phase[0])
            begin
                if (ramp >= LEVEL_TOP)
                begin
                    phase = phase + 4'd1;
                    ramp = LEVEL_FULL;
                end
                else
                    ramp = ramp + 8'd1;
            end
            else
            begin
                if (ramp <= 8'd1)
                begin
                    phase = (phase == 4'd5) ? 4'd0 : phase + 4'd1;
                    ramp = 8'd0;
                end
                else
                    ramp = ramp - 8'd1;
            end
        endfunction

        function void heart_step();
            if (phase > 2) restart();
            if (phase == 4'd0)
            begin
                if (ramp < HEART_LOW) ramp = HEART_LOW;
                paint(ramp, 8'd0, 8'd0);
                if (dwell_done(32'(HEART_STEP_MS)))
                begin
                    if (ramp >= LEVEL_TOP)
                    begin
                        phase = 4'd1;
                        ramp = LEVEL_FULL;
                    end
                    else
                        ramp = ramp + 8'd1;
                end
            end
            else if (phase == 4'd1)
            begin
                if (ramp < HEART_FALL) ramp = HEART_FALL;
                paint(ramp, 8'd0, 8'd0);
                if (dwell_done(32'(HEART_STEP_MS)))
                begin
                    if (ramp <= HEART_FALL)
                    begin
                        beats = beats + 2'd1;
                        if (beats >= 2'd2)
                        begin
                            beats = '0;
                            phase = 4'd2;
                        end
                        else
                            phase = 4'd0;
                        ramp = HEART_LOW;
                    end
                    else
                        ramp = ramp - 8'd1;
                end
            end
            else
            begin
                paint(lit.red, 8'd0, 8'd0);
                if (dwell_done(32'(PAUSE_MS)))
                begin
                    phase = 4'd0;
                    ramp = HEART_LOW;
                end
            end
        endfunction

        function void flash_step();
            int unsigned d;
            d = 32'(regs.step_delay_ms);
            if (d < 32'(FLASH_MIN_MS)) d = 32'(FLASH_MIN_MS);
            if (phase > 5) restart();
            case (phase)
                0:       paint(LEVEL_FULL, 8'd0, 8'd0);
                2:       paint(8'd0, LEVEL_FULL, 8'd0);
                4:       paint(8'd0, 8'd0, LEVEL_FULL);
                default: paint(8'd0, 8'd0, 8'd0);
            endcase
            if (dwell_done(d * 32'(FLASH_MUL)))
                phase = (phase == 4'd5) ? 4'd0 : phase + 4'd1;
        endfunction

        function void blink_step();
            if (phase > 1) restart();
            if (phase == 4'd0)
                paint(regs.static_red, regs.static_green, regs.static_blue);
            else
                paint(8'd0, 8'd0, 8'd0);
            if (dwell_done(delay_ms() * 32'(BLINK_MUL)))
                phase[0] = ~phase[0];
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_POWER_ON:     regs.power_on = val[0];
                REG_ANIMATED:     regs.animated_mode = val[0];
                REG_PROFILE:
                begin
                    regs.effect_profile = val[2:0];
                    restart();
                end
                REG_STATIC_RED:   regs.static_red = val[7:0];
                REG_STATIC_GREEN: regs.static_green = val[7:0];
                REG_STATIC_BLUE:  regs.static_blue = val[7:0];
                REG_STEP_DELAY:   regs.step_delay_ms = val;
                default: ;
            endcase
        endfunction

        function void note_tick(bit t);
            if (!regs.power_on)
            begin
                paint(8'd0, 8'd0, 8'd0);
                restart();
            end
            else if (!regs.animated_mode)
            begin
                paint(regs.static_red, regs.static_green, regs.static_blue);
                restart();
            end
            else if (t)
            begin
                case (regs.effect_profile)
                    PROF_WAVE:  wave_step();
                    PROF_HEART: heart_step();
                    PROF_FLASH: flash_step();
                    PROF_BLINK: blink_step();
                    default: ;
                endcase
            end
            colour_queue.push_back(lit);
        endfunction

        function void check_word(logic [23:0] word);
            rles_rgb_t seen;
            rles_rgb_t want;
            seen = word;
            if (colour_queue.size() == 0)
            begin
                $error("colour word %h with no tick waiting", word);
                errors++;
                return;
            end
            want = colour_queue.pop_front();
            if (seen.red !== want.red)
            begin
                $error("red_level: expected %0d actual %0d", want.red, seen.red);
                errors++;
            end
            if (seen.green !== want.green)
            begin
                $error("green_level: expected %0d actual %0d", want.green, seen.green);
                errors++;
            end
            if (seen.blue !== want.blue)
            begin
                $error("blue_level: expected %0d actual %0d", want.blue, seen.blue);
                errors++;
            end
        endfunction

        function int pending();
            return colour_queue.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [23:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    led_scoreboard sb;
    bit            hold_req = 1'b0;
    int            ticks_sent = 0;

    rgb_led_effect_sequencer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    // also closes any burst of register writes before the first tick word
    task automatic send_tick(bit t, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        cfg_valid = 1'b0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {7'd0, t};
        do @(posedge clk); while (!s_tready);
        sb.note_tick(t);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic quiesce();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic run_ticks(int n, int tick_pct, bit burst);
        repeat (n) send_tick($urandom_range(0, 99) < tick_pct, burst);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return 10'd0;
            1:       return 10'd1023;
            2:       return 10'($urandom_range(0, 1023));
            default: return 10'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 10'd0;
            1:       return 10'd255;
            default: return 10'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_profile();
        int r;
        r = $urandom_range(0, 3);
        if ($urandom_range(0, 5) != 0) return 10'($urandom_range(1, 4));
        return (r == 0) ? 10'd0 : 10'(r + 4);
    endfunction

    initial
    begin
        int  count;
        int  gap;
        bit  rx_burst;
        count = 0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (count % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
            if (hold_req)
            begin
                gap = 200;
                hold_req = 1'b0;
            end
            else
                gap = rx_burst ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_word(m_tdata);
            count++;
            @(negedge clk);
        end
    end

    initial
    begin
        int n;
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // power off after reset
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);

        quiesce();
        cfg_write(REG_UNUSED, 10'h3FF);
        cfg_write(REG_POWER_ON, 10'd1);
        cfg_write(REG_STATIC_RED, 10'd255);
        cfg_write(REG_STATIC_GREEN, 10'd0);
        cfg_write(REG_STATIC_BLUE, 10'd128);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        quiesce();
        cfg_write(REG_ANIMATED, 10'd1);
        cfg_write(REG_STEP_DELAY, 10'd0);
        cfg_write(REG_PROFILE, 10'(PROF_WAVE));
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        quiesce();
        cfg_write(REG_PROFILE, 10'(PROF_HEART));
        run_ticks(3, 100, 1'b1);

        quiesce();
        cfg_write(REG_STEP_DELAY, 10'd1023);
        cfg_write(REG_PROFILE, 10'(PROF_FLASH));
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        // blink reads the static colour live
        quiesce();
        cfg_write(REG_STEP_DELAY, 10'd1);
        cfg_write(REG_PROFILE, 10'(PROF_BLINK));
        send_tick(1'b1, 1'b0);
        quiesce();
        cfg_write(REG_STATIC_RED, 10'd0);
        cfg_write(REG_STATIC_GREEN, 10'd255);
        cfg_write(REG_STATIC_BLUE, 10'd0);
        send_tick(1'b1, 1'b0);

        quiesce();
        cfg_write(REG_PROFILE, 10'd5);
        send_tick(1'b1, 1'b0);
        quiesce();
        cfg_write(REG_PROFILE, 10'd7);
        send_tick(1'b1, 1'b0);
        quiesce();
        cfg_write(REG_PROFILE, 10'd0);
        send_tick(1'b1, 1'b0);

        // same profile written again still restarts
        quiesce();
        cfg_write(REG_PROFILE, 10'(PROF_BLINK));
        cfg_write(REG_PROFILE, 10'(PROF_BLINK));
        send_tick(1'b1, 1'b0);

        quiesce();
        cfg_write(REG_POWER_ON, 10'd0);
        send_tick(1'b1, 1'b0);
        quiesce();
        cfg_write(REG_POWER_ON, 10'd1);
        cfg_write(REG_ANIMATED, 10'd0);
        send_tick(1'b1, 1'b0);

        // back-pressure phase: receiver holds off while words keep coming
        quiesce();
        cfg_write(REG_ANIMATED, 10'd1);
        cfg_write(REG_STEP_DELAY, 10'd2);
        cfg_write(REG_PROFILE, 10'(PROF_FLASH));
        hold_req = 1'b1;
        run_ticks(150, 95, 1'b1);

        while (ticks_sent < TICK_TARGET)
        begin
            quiesce();
            if ($urandom_range(0, 9) < 3)
                cfg_write(REG_POWER_ON, 10'($urandom_range(0, 9) != 0));
            if ($urandom_range(0, 9) < 3)
                cfg_write(REG_ANIMATED, 10'($urandom_range(0, 7) != 0));
            if ($urandom_range(0, 9) < 4) cfg_write(REG_PROFILE, pick_profile());
            if ($urandom_range(0, 9) < 3) cfg_write(REG_STATIC_RED, pick_level());
            if ($urandom_range(0, 9) < 3) cfg_write(REG_STATIC_GREEN, pick_level());
            if ($urandom_range(0, 9) < 3) cfg_write(REG_STATIC_BLUE, pick_level());
            if ($urandom_range(0, 9) < 4) cfg_write(REG_STEP_DELAY, pick_delay());
            if ($urandom_range(0, 19) == 0)
                cfg_write(REG_UNUSED, 10'($urandom_range(0, 1023)));
            n = $urandom_range(20, 300);
            if (n > TICK_TARGET - ticks_sent) n = TICK_TARGET - ticks_sent;
            run_ticks(n, ($urandom_range(0, 3) == 0) ? 50 : 90, $urandom_range(0, 2) == 0);
        end

        quiesce();
        repeat (8) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> rgb_led_effect_sequencer.f
rtl/core/rles_pkg.sv
rtl/core/rles_cfg.sv
rtl/core/rles_fx.sv
rtl/core/rgb_led_effect_sequencer.sv
tb/tb_rgb_led_effect_sequencer.sv
